[rtl/core/shpa_pkg.sv]
// Package for the sensor hub poll aggregator.
// Holds the protocol bytes, register indexes and the job record handed to the transmitter.
// No dependencies.
`default_nettype none
package shpa_pkg;

  localparam logic [7:0] START_BYTE    = 8'h68;
  localparam logic [7:0] HOST_E        = 8'h65;
  localparam logic [7:0] HOST_Y        = 8'h79;
  localparam logic [7:0] BASE_RESET    = 8'h61;
  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [1:0] FRAME_LEN     = 2'd2;
  localparam int unsigned HEADER_BEATS = 3;

  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_BASE    = 1'b1;

  typedef struct packed {
    logic       valid;
    logic       host;
    logic [7:0] poll_byte;
  } job_t;

endpackage
`default_nettype wire

[rtl/core/shpa_ctrl.sv]
// Poll control: registers, round robin, timeout, deframer and mask scatter.
// Depends on shpa_pkg; feeds at most one job per request to shpa_tx.
`default_nettype none
module shpa_ctrl
  import shpa_pkg::*;
#(
  parameter int BOARDS          = 3,
  parameter int STRINGS         = 4,
  parameter int FRETS_PER_BOARD = 2
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_index,
  input  wire logic [15:0]              cfg_data,
  input  wire logic                     in_valid,
  input  wire logic                     in_op,
  input  wire logic [7:0]               in_byte,
  input  wire logic                     tx_free,
  output logic                          advance,
  output job_t                          job,
  output logic [STRINGS-1:0][7:0]       masks_next
);

  logic [15:0]              timeout_ticks;
  logic [7:0]               poll_base;
  logic [1:0]               board;
  logic                     poll_open;
  logic [15:0]              wait_count;
  logic [1:0]               frame_pos;
  logic [7:0]               first_byte;
  logic [STRINGS-1:0][7:0]  masks;

  logic [1:0]               board_next;
  logic                     poll_open_next;
  logic [15:0]              wait_count_next;
  logic [1:0]               frame_pos_next;
  logic [7:0]               first_byte_next;
  logic [15:0]              wait_inc;
  logic [1:0]               pos0;
  logic                     finish;
  logic                     frame_done;
  logic [5:0]               bit_pos;

  always_comb begin
    board_next      = board;
    poll_open_next  = poll_open;
    wait_count_next = wait_count;
    frame_pos_next  = frame_pos;
    first_byte_next = first_byte;
    masks_next      = masks;
    finish          = 1'b0;
    frame_done      = 1'b0;
    job             = '0;
    bit_pos         = '0;
    wait_inc        = (wait_count == 16'hFFFF) ? wait_count : wait_count + 16'd1;
    pos0            = ((in_byte == START_BYTE) || (frame_pos >= FRAME_LEN)) ? 2'd0 : frame_pos;

    if (in_op) begin
      if (!poll_open) begin
        poll_open_next  = 1'b1;
        wait_count_next = '0;
        job.valid       = 1'b1;
        job.host        = 1'b0;
        job.poll_byte   = poll_base + {6'd0, board};
      end else begin
        wait_count_next = wait_inc;
        finish          = (wait_inc >= timeout_ticks);
      end
    end else if (poll_open) begin
      if (pos0 == 2'd0) begin
        first_byte_next = in_byte;
      end
      frame_pos_next = pos0 + 2'd1;
      frame_done     = (first_byte_next == START_BYTE) && (frame_pos_next == FRAME_LEN);
      finish         = frame_done;
    end

    if (frame_done) begin
      for (int r = 0; r < STRINGS * FRETS_PER_BOARD; r++) begin
        bit_pos = 6'(board) * 6'(FRETS_PER_BOARD) + 6'(r / STRINGS);
        if (bit_pos < 6'd8) begin
          masks_next[r % STRINGS][bit_pos[2:0]] = (r < 8) ? in_byte[r % 8] : 1'b0;
        end
      end
    end

    if (finish) begin
      poll_open_next  = 1'b0;
      wait_count_next = '0;
      board_next      = (board == 2'(BOARDS - 1)) ? 2'd0 : board + 2'd1;
      if (board_next == 2'd0) begin
        job.valid = 1'b1;
        job.host  = 1'b1;
      end
    end

    job.valid = job.valid & in_valid;
    advance   = in_valid && (!job.valid || tx_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      poll_base     <= BASE_RESET;
      board         <= '0;
      poll_open     <= 1'b0;
      wait_count    <= '0;
      frame_pos     <= '0;
      first_byte    <= '0;
      masks         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TIMEOUT: timeout_ticks <= cfg_data;
          REG_BASE:    poll_base     <= cfg_data[7:0];
          default:     poll_base     <= poll_base;
        endcase
      end
      if (advance) begin
        board      <= board_next;
        poll_open  <= poll_open_next;
        wait_count <= wait_count_next;
        frame_pos  <= frame_pos_next;
        first_byte <= first_byte_next;
        masks      <= masks_next;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/shpa_tx.sv]
// Result register and serialiser: one poll byte, or header plus mask bytes to the host.
// Depends on shpa_pkg; loaded by shpa_ctrl.
`default_nettype none
module shpa_tx
  import shpa_pkg::*;
#(
  parameter int STRINGS = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire job_t                     job,
  input  wire logic [STRINGS-1:0][7:0]  masks_in,
  output logic                          free,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logic [7:0]                    m_tdata,
  output logic                          m_tuser,
  output logic                          m_tlast
);

  localparam int BEATS = HEADER_BEATS + STRINGS;
  localparam int CW    = $clog2(BEATS);

  logic                     active;
  logic                     host;
  logic [CW-1:0]            cnt;
  logic [7:0]               poll_byte;
  logic [STRINGS-1:0][7:0]  masks;
  logic                     taken;

  always_comb begin
    m_tvalid = active;
    m_tuser  = host;
    m_tlast  = !host || (cnt == CW'(BEATS - 1));
    if (!host) begin
      m_tdata = poll_byte;
    end else begin
      case (cnt)
        CW'(0):  m_tdata = START_BYTE;
        CW'(1):  m_tdata = HOST_E;
        CW'(2):  m_tdata = HOST_Y;
        default: m_tdata = masks[0];
      endcase
    end
    taken = active && m_tready;
    free  = !active || (taken && m_tlast);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      host   <= 1'b0;
      cnt    <= '0;
    end else begin
      if (job.valid && free) begin
        active <= 1'b1;
        host   <= job.host;
        cnt    <= '0;
      end else if (taken) begin
        if (m_tlast) begin
          active <= 1'b0;
        end else begin
          cnt <= cnt + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job.valid && free) begin
      poll_byte <= job.poll_byte;
      masks     <= masks_in;
    end else if (taken && host && (cnt >= CW'(HEADER_BEATS))) begin
      for (int i = 0; i < STRINGS - 1; i++) begin
        masks[i] <= masks[i + 1];
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/sensor_hub_poll_aggregator.sv]
// Top level of the sensor hub poll aggregator.
// Depends on shpa_pkg, shpa_ctrl and shpa_tx.
//
// Usage:
//   Slave stream: s_tuser = operation (0 board byte, 1 timer tick), s_tdata = rx_byte.
//   Master stream: m_tuser = link (0 board, 1 host), m_tdata = tx_byte,
//   m_tlast marks the final byte caused by one request.
//   Config port: cfg_we, cfg_index (0 timeout_ticks, 1 poll_address_base), cfg_data.
//   A request is processed in the cycle it sits in the input register and lands
//   in the result register at the next edge; its first byte is offered from the
//   result register. Requests that cause no byte pass at one per cycle. A poll
//   byte, or a host report of header and STRINGS mask bytes, holds the result
//   register until its last byte is taken; the next request is processed in the cycle the last byte is taken.
//   Reset restores both registers to their defaults, closes any poll, selects
//   board zero and clears the deframer and all string masks.
//   While m_tready is low the result register holds; a request with bytes to
//   send waits in the input register and s_tready drops; no byte is lost or repeated.
`default_nettype none
module sensor_hub_poll_aggregator
  import shpa_pkg::*;
#(
  parameter int BOARDS          = 3,
  parameter int STRINGS         = 4,
  parameter int FRETS_PER_BOARD = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic        s_tuser,   // [0] operation
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] tx_byte
  output logic             m_tuser,   // [0] link
  output logic             m_tlast
);

  logic                     in_valid;
  logic                     in_op;
  logic [7:0]               in_byte;
  logic                     advance;
  logic                     tx_free;
  job_t                     job;
  logic [STRINGS-1:0][7:0]  masks_next;

  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op   <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  shpa_ctrl #(
    .BOARDS          (BOARDS),
    .STRINGS         (STRINGS),
    .FRETS_PER_BOARD (FRETS_PER_BOARD)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_op      (in_op),
    .in_byte    (in_byte),
    .tx_free    (tx_free),
    .advance    (advance),
    .job        (job),
    .masks_next (masks_next)
  );

  shpa_tx #(
    .STRINGS (STRINGS)
  ) u_tx (
    .clk      (clk),
    .rst      (rst),
    .job      (job),
    .masks_in (masks_next),
    .free     (tx_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire
